// File: src/dbtm_pkg.sv
// Shared types and constants for the depth background touch mask.
`timescale 1ns / 1ps

package dbtm_pkg;

    localparam int FRAME_WIDTH  = 512;
    localparam int FRAME_HEIGHT = 512;
    localparam int ADDR_W       = $clog2(FRAME_WIDTH * FRAME_HEIGHT);

    localparam int COORD_W  = 9;
    localparam int DEPTH_W  = 16;
    localparam int DIFF_W   = 17;
    localparam int REGION_W = 10;
    localparam int SQ_W     = 20;

    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam logic OP_PROCESS = 1'b0;
    localparam logic OP_CAPTURE = 1'b1;

    typedef enum logic [2:0] {
        REG_MIN_THRESHOLD = 3'd0,
        REG_MAX_THRESHOLD = 3'd1,
        REG_CIRCLE_COL    = 3'd2,
        REG_CIRCLE_ROW    = 3'd3,
        REG_CIRCLE_RSQ    = 3'd4,
        REG_MODE_FLAGS    = 3'd5,
        REG_REGION_COLS   = 3'd6,
        REG_REGION_ROWS   = 3'd7
    } dbtm_reg_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] min_threshold;
        logic signed [DIFF_W-1:0] max_threshold;
        logic [COORD_W-1:0]       circle_col;
        logic [COORD_W-1:0]       circle_row;
        logic [SQ_W-1:0]          circle_rsq;
        logic                     mirror_en;
        logic                     circle_en;
        logic [2*REGION_W-1:0]    region_cols;
        logic [2*REGION_W-1:0]    region_rows;
    } dbtm_cfg_t;

endpackage

// File: src/dbtm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dbtm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/dbtm_cfg.sv
// APB register file for thresholds, circle mask, mode and output region.
`timescale 1ns / 1ps

module dbtm_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dbtm_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [dbtm_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [dbtm_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready,
    output dbtm_pkg::dbtm_cfg_t                cfg
);
    import dbtm_pkg::*;

    dbtm_cfg_t cfg_reg;
    dbtm_reg_t idx;
    logic      wr;

    assign pready = 1'b1;
    assign idx    = dbtm_reg_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_threshold <= '0;
            cfg_reg.max_threshold <= DIFF_W'(65535);
            cfg_reg.circle_col    <= COORD_W'(256);
            cfg_reg.circle_row    <= COORD_W'(212);
            cfg_reg.circle_rsq    <= '1;
            cfg_reg.mirror_en     <= 1'b0;
            cfg_reg.circle_en     <= 1'b0;
            cfg_reg.region_cols   <= (2*REGION_W)'(512 << REGION_W);
            cfg_reg.region_rows   <= (2*REGION_W)'(512 << REGION_W);
        end else if (wr) begin
            unique case (idx)
                REG_MIN_THRESHOLD: cfg_reg.min_threshold <= pwdata[DIFF_W-1:0];
                REG_MAX_THRESHOLD: cfg_reg.max_threshold <= pwdata[DIFF_W-1:0];
                REG_CIRCLE_COL:    cfg_reg.circle_col    <= pwdata[COORD_W-1:0];
                REG_CIRCLE_ROW:    cfg_reg.circle_row    <= pwdata[COORD_W-1:0];
                REG_CIRCLE_RSQ:    cfg_reg.circle_rsq    <= pwdata[SQ_W-1:0];
                REG_MODE_FLAGS: begin
                    cfg_reg.mirror_en <= pwdata[0];
                    cfg_reg.circle_en <= pwdata[1];
                end
                REG_REGION_COLS:   cfg_reg.region_cols   <= pwdata[2*REGION_W-1:0];
                REG_REGION_ROWS:   cfg_reg.region_rows   <= pwdata[2*REGION_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_MIN_THRESHOLD: prdata = CFG_DATA_W'(cfg_reg.min_threshold);
            REG_MAX_THRESHOLD: prdata = CFG_DATA_W'(cfg_reg.max_threshold);
            REG_CIRCLE_COL:    prdata = CFG_DATA_W'(cfg_reg.circle_col);
            REG_CIRCLE_ROW:    prdata = CFG_DATA_W'(cfg_reg.circle_row);
            REG_CIRCLE_RSQ:    prdata = CFG_DATA_W'(cfg_reg.circle_rsq);
            REG_MODE_FLAGS:    prdata = CFG_DATA_W'({cfg_reg.circle_en, cfg_reg.mirror_en});
            REG_REGION_COLS:   prdata = CFG_DATA_W'(cfg_reg.region_cols);
            REG_REGION_ROWS:   prdata = CFG_DATA_W'(cfg_reg.region_rows);
            default:           prdata = '0;
        endcase
    end

endmodule

// File: src/depth_background_touch_mask.sv
// Top level: background frame subtraction, threshold, circle and region touch mask.
//
//  channel | direction | tdata (low bit up)                     | side fields
//  s_      | in        | col[8:0] row[17:9] depth[33:18], 0 pad | tuser=operation tlast=frame_end
//  m_      | out       | out_col[8:0] out_row[17:9] mark[18]    | -
//  apb     | in        | 8 registers at 4*i, paddr[4:2]         | pready tied high
//
// One item per cycle unless m_ stalls; items pass the stage 1 then the output register.
// The stage split is set by the background RAM: read issued at accept, data in the next cycle.
// Reset clears background_ready and all valid flags; the background RAM is not cleared.
// A stalled m_ side holds the output register and then the stage behind it.
`timescale 1ns / 1ps

module depth_background_touch_mask (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dbtm_pkg::S_TDATA_W-1:0]    s_tdata,   // col, row, depth
    input  logic                              s_tuser,   // operation
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dbtm_pkg::M_TDATA_W-1:0]    m_tdata,   // out_col, out_row, mark
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dbtm_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [dbtm_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [dbtm_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import dbtm_pkg::*;

    dbtm_cfg_t cfg;

    dbtm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // stage 0: accept, address, store decision, geometry
    logic               accept;
    logic               in_op;
    logic [COORD_W-1:0] in_col;
    logic [COORD_W-1:0] in_row;
    logic [DEPTH_W-1:0] in_depth;
    logic               in_frame;
    logic               store;
    logic [ADDR_W-1:0]  addr;
    logic [COORD_W-1:0] ocol;
    logic               in_region;
    logic signed [SQ_W-1:0] dx;
    logic signed [SQ_W-1:0] dy;
    logic               bg_ready_reg;
    logic               bg_ready_next;
    logic [DEPTH_W-1:0] bg_rdata;

    logic               s1_valid_reg;
    logic [COORD_W-1:0] s1_ocol_reg;
    logic [COORD_W-1:0] s1_row_reg;
    logic               s1_check_reg;
    logic [DEPTH_W-1:0] s1_depth_reg;
    logic [SQ_W-1:0]    s1_dx_sq_reg;
    logic [SQ_W-1:0]    s1_dy_sq_reg;

    logic               m_valid_reg;
    logic [COORD_W-1:0] m_col_reg;
    logic [COORD_W-1:0] m_row_reg;
    logic               m_mark_reg;

    logic               out_free;
    logic               s1_mark;
    logic signed [DIFF_W-1:0] diff;
    logic [SQ_W-1:0]    dist_sq;

    assign in_op    = s_tuser;
    assign in_col   = s_tdata[COORD_W-1:0];
    assign in_row   = s_tdata[2*COORD_W-1:COORD_W];
    assign in_depth = s_tdata[2*COORD_W+DEPTH_W-1:2*COORD_W];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    assign in_frame = (int'(in_col) < FRAME_WIDTH) && (int'(in_row) < FRAME_HEIGHT);
    assign store    = (in_op == OP_CAPTURE) || !bg_ready_reg;
    assign addr     = ADDR_W'(32'(in_row) * 32'(FRAME_WIDTH) + 32'(in_col));

    assign ocol = (in_frame && cfg.mirror_en) ?
                  COORD_W'(FRAME_WIDTH - 1 - int'(in_col)) : in_col;

    assign in_region =
        ({1'b0, ocol}   >= cfg.region_cols[REGION_W-1:0]) &&
        ({1'b0, ocol}   <  cfg.region_cols[2*REGION_W-1:REGION_W]) &&
        ({1'b0, in_row} >= cfg.region_rows[REGION_W-1:0]) &&
        ({1'b0, in_row} <  cfg.region_rows[2*REGION_W-1:REGION_W]);

    assign dx = $signed(SQ_W'(cfg.circle_col)) - $signed(SQ_W'(in_col));
    assign dy = $signed(SQ_W'(cfg.circle_row)) - $signed(SQ_W'(in_row));

    assign bg_ready_next = (accept && store && s_tlast) ? 1'b1 : bg_ready_reg;

    dbtm_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (FRAME_WIDTH * FRAME_HEIGHT)
    ) u_bg_ram (
        .aclk  (aclk),
        .we    (accept && in_frame && store),
        .waddr (addr),
        .wdata (in_depth),
        .re    (accept),
        .raddr (addr),
        .rdata (bg_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bg_ready_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end else begin
            bg_ready_reg <= bg_ready_next;
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_ocol_reg  <= ocol;
            s1_row_reg   <= in_row;
            s1_check_reg <= in_frame && !store && (in_depth != '0) && in_region;
            s1_depth_reg <= in_depth;
            s1_dx_sq_reg <= SQ_W'(dx * dx);
            s1_dy_sq_reg <= SQ_W'(dy * dy);
        end
    end

    // stage 1: compare against background read back from RAM
    assign diff    = $signed({1'b0, s1_depth_reg}) - $signed({1'b0, bg_rdata});
    assign dist_sq = s1_dx_sq_reg + s1_dy_sq_reg;
    assign s1_mark = s1_check_reg &&
                     (diff > cfg.min_threshold) && (diff < cfg.max_threshold) &&
                     (!cfg.circle_en || (dist_sq < cfg.circle_rsq));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && s1_valid_reg) begin
            m_col_reg  <= s1_ocol_reg;
            m_row_reg  <= s1_row_reg;
            m_mark_reg <= s1_mark;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_mark_reg, m_row_reg, m_col_reg});

    // background_ready only ever sets
    a_ready_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(bg_ready_reg))
        else $error("background_ready cleared outside reset");

    a_ready_set: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && store && s_tlast |=> bg_ready_reg)
        else $error("background_ready not set after last stored item");

    a_no_mark_unchecked: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_check_reg |-> !s1_mark)
        else $error("mark on a store or invalid item");

    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !out_free |=> s1_valid_reg && $stable(s1_ocol_reg)
            && $stable(bg_rdata))
        else $error("stage 1 item lost while output stalled");

endmodule

// File: verif/dbtm_checker.sv
// Checker for the depth background touch mask: tracks registers, predicts each mask item, compares.
`timescale 1ns / 1ps

module dbtm_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [dbtm_pkg::S_TDATA_W-1:0]  s_tdata,   // col, row, depth
    input  logic                            s_tuser,   // operation
    input  logic                            s_tlast,   // frame_end
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [dbtm_pkg::M_TDATA_W-1:0]  m_tdata,   // out_col, out_row, mark
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dbtm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [dbtm_pkg::CFG_DATA_W-1:0] pwdata,
    input  logic                            pready,
    output int                              fail_count,
    output int                              pending
);
    import dbtm_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               mark;
    } px_mask_t;

    px_mask_t           due_masks[$];
    px_mask_t           oldest;
    logic [DEPTH_W-1:0] bg_frame [FRAME_WIDTH*FRAME_HEIGHT];
    logic               bg_ready;
    dbtm_cfg_t          regs;
    int                 mismatches;

    function automatic logic in_span(input int v, input logic [2*REGION_W-1:0] span);
        return v >= int'(span[REGION_W-1:0]) && v < int'(span[2*REGION_W-1:REGION_W]);
    endfunction

    function automatic px_mask_t touch_mask_of(input logic op, input logic [COORD_W-1:0] col,
                                               input logic [COORD_W-1:0] row,
                                               input logic [DEPTH_W-1:0] depth,
                                               input logic last);
        px_mask_t r;
        int       idx;
        int       diff;
        int       dx;
        int       dy;
        logic     store;
        logic     hit;
        idx   = int'(row) * FRAME_WIDTH + int'(col);
        store = (op == OP_CAPTURE) || !bg_ready;
        r.col  = regs.mirror_en ? COORD_W'(FRAME_WIDTH - 1 - int'(col)) : col;
        r.row  = row;
        r.mark = 1'b0;
        if (store) begin
            bg_frame[idx] = depth;
        end else begin
            diff = int'(depth) - int'(bg_frame[idx]);
            hit  = depth != '0 && diff > int'($signed(regs.min_threshold))
                   && diff < int'($signed(regs.max_threshold));
            if (hit && regs.circle_en) begin
                dx  = int'(regs.circle_col) - int'(col);
                dy  = int'(regs.circle_row) - int'(row);
                hit = dx * dx + dy * dy < int'(regs.circle_rsq);
            end
            if (hit && in_span(int'(r.col), regs.region_cols)
                    && in_span(int'(row), regs.region_rows)) begin
                r.mark = 1'b1;
            end
        end
        if (store && last) begin
            bg_ready = 1'b1;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            due_masks.delete();
            bg_ready           = 1'b0;
            mismatches         = 0;
            regs.min_threshold = 17'sd0;
            regs.max_threshold = 17'sd65535;
            regs.circle_col    = 9'd256;
            regs.circle_row    = 9'd212;
            regs.circle_rsq    = 20'hFFFFF;
            regs.mirror_en     = 1'b0;
            regs.circle_en     = 1'b0;
            regs.region_cols   = 20'd512 << REGION_W;
            regs.region_rows   = 20'd512 << REGION_W;
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_masks.size() == 0) begin
                    $error("unexpected result item: tdata %h", m_tdata);
                    mismatches++;
                end else begin
                    oldest = due_masks.pop_front();
                    if (m_tdata[COORD_W-1:0] !== oldest.col) begin
                        $error("out_col: expected %0d, actual %0d",
                               oldest.col, m_tdata[COORD_W-1:0]);
                        mismatches++;
                    end
                    if (m_tdata[2*COORD_W-1:COORD_W] !== oldest.row) begin
                        $error("out_row: expected %0d, actual %0d",
                               oldest.row, m_tdata[2*COORD_W-1:COORD_W]);
                        mismatches++;
                    end
                    if (m_tdata[2*COORD_W] !== oldest.mark) begin
                        $error("mark: expected %0d, actual %0d",
                               oldest.mark, m_tdata[2*COORD_W]);
                        mismatches++;
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (dbtm_reg_t'(paddr[4:2]))
                    REG_MIN_THRESHOLD: regs.min_threshold = pwdata[DIFF_W-1:0];
                    REG_MAX_THRESHOLD: regs.max_threshold = pwdata[DIFF_W-1:0];
                    REG_CIRCLE_COL:    regs.circle_col    = pwdata[COORD_W-1:0];
                    REG_CIRCLE_ROW:    regs.circle_row    = pwdata[COORD_W-1:0];
                    REG_CIRCLE_RSQ:    regs.circle_rsq    = pwdata[SQ_W-1:0];
                    REG_MODE_FLAGS: begin
                        regs.mirror_en = pwdata[0];
                        regs.circle_en = pwdata[1];
                    end
                    REG_REGION_COLS:   regs.region_cols   = pwdata[2*REGION_W-1:0];
                    REG_REGION_ROWS:   regs.region_rows   = pwdata[2*REGION_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                due_masks = {due_masks, touch_mask_of(s_tuser, s_tdata[COORD_W-1:0],
                                                      s_tdata[2*COORD_W-1:COORD_W],
                                                      s_tdata[2*COORD_W+DEPTH_W-1:2*COORD_W],
                                                      s_tlast)};
            end
        end
        fail_count <= mismatches;
        pending    <= due_masks.size();
    end

endmodule

// File: verif/testbench.sv
// Testbench top: clock, reset, register phases and pixel stimulus for the touch mask block.
`timescale 1ns / 1ps

module testbench;
    import dbtm_pkg::*;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;   // col[8:0] row[17:9] depth[33:18], zero pad
    logic                  s_tuser  = 1'b0; // operation
    logic                  s_tlast  = 1'b0; // frame_end
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // out_col[8:0] out_row[17:9] mark[18]
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;

    bit quiet      = 1'b0;
    int gap_pct    = 0;
    int stall_pct  = 0;
    int stall_left = 0;

    // stimulus-side record of what the background holds, so reads never hit unwritten entries
    bit                 gen_ready = 1'b0;
    logic [DEPTH_W-1:0] stored_depth [int];
    int                 stored_pos[$];
    int                 cur_min = 0;
    int                 cur_max = 65535;

    always #5 aclk = ~aclk;

    depth_background_touch_mask uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    dbtm_checker mask_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .pending(pending)
    );

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            m_tready   <= 1'b0;
            stall_left = $urandom_range(0, 12);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic apb_write(input dbtm_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_registers(input int mn, input int mx, input int cx, input int cy,
                                 input int rsq, input int mode, input int rcols, input int rrows);
        apb_write(REG_MIN_THRESHOLD, mn & 32'h1FFFF);
        apb_write(REG_MAX_THRESHOLD, mx & 32'h1FFFF);
        apb_write(REG_CIRCLE_COL, cx & 32'h1FF);
        apb_write(REG_CIRCLE_ROW, cy & 32'h1FF);
        apb_write(REG_CIRCLE_RSQ, rsq & 32'hFFFFF);
        apb_write(REG_MODE_FLAGS, mode & 32'h3);
        apb_write(REG_REGION_COLS, rcols & 32'hFFFFF);
        apb_write(REG_REGION_ROWS, rrows & 32'hFFFFF);
        cur_min = mn;
        cur_max = mx;
    endtask

    // hold the sender until every predicted mask item has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic send_px(input logic op, input int col, input int row, input int depth,
                           input logic last);
        int idx;
        int n;
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            n = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= last;
        s_tdata  <= S_TDATA_W'({depth[DEPTH_W-1:0], row[COORD_W-1:0], col[COORD_W-1:0]});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        idx = row * FRAME_WIDTH + col;
        if (op == OP_CAPTURE || !gen_ready) begin
            if (!stored_depth.exists(idx)) stored_pos = {stored_pos, idx};
            stored_depth[idx] = depth[DEPTH_W-1:0];
            if (last) gen_ready = 1'b1;
        end
    endtask

    task automatic random_item();
        int kind;
        int idx;
        int d;
        int lo;
        int hi;
        kind = $urandom_range(0, 99);
        if (kind < 15 || stored_pos.size() == 0) begin
            send_px(OP_CAPTURE, $urandom_range(0, 511), $urandom_range(0, 511),
                    $urandom_range(0, 65535), $urandom_range(0, 31) == 0);
        end else begin
            idx = stored_pos[$urandom_range(0, stored_pos.size() - 1)];
            if (kind < 22) begin
                d = $urandom_range(0, 1) ? 0 : int'($urandom_range(0, 65535));
            end else begin
                // aim the difference at the threshold window
                lo = cur_min - 3;
                hi = cur_max + 3;
                if (hi < lo || hi - lo > 4000)
                    d = int'(stored_depth[idx]) + int'($urandom_range(0, 8000)) - 4000;
                else
                    d = int'(stored_depth[idx]) + lo + int'($urandom_range(0, hi - lo));
                if (d < 0) d = 0;
                if (d > 65535) d = 65535;
            end
            send_px(OP_PROCESS, idx % FRAME_WIDTH, idx / FRAME_WIDTH, d,
                    $urandom_range(0, 63) == 0);
        end
    endtask

    initial begin
        int ph;
        int n;
        int mn;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        gap_pct   = 30;
        stall_pct = 30;

        // first frame: process items store until frame_end
        send_px(OP_PROCESS, 0, 0, 0, 1'b0);
        send_px(OP_PROCESS, 511, 511, 65535, 1'b0);
        send_px(OP_CAPTURE, 511, 0, 1000, 1'b0);
        send_px(OP_CAPTURE, 10, 10, 2000, 1'b0);
        send_px(OP_CAPTURE, 13, 14, 2000, 1'b0);
        send_px(OP_CAPTURE, 13, 13, 2000, 1'b0);
        send_px(OP_CAPTURE, 5, 20, 3000, 1'b0);
        send_px(OP_CAPTURE, 4, 7, 100, 1'b0);
        send_px(OP_PROCESS, 0, 511, 500, 1'b1);
        // background ready: invalid depth, strict bounds, capture answers unmarked
        send_px(OP_PROCESS, 0, 0, 0, 1'b0);
        send_px(OP_PROCESS, 0, 0, 1, 1'b0);
        send_px(OP_PROCESS, 511, 511, 65535, 1'b0);
        send_px(OP_PROCESS, 511, 0, 1001, 1'b0);
        send_px(OP_CAPTURE, 511, 0, 65535, 1'b1);
        send_px(OP_PROCESS, 511, 0, 65534, 1'b0);

        // circle edge is exclusive, threshold edges exclusive
        drain();
        set_registers(-10, 10, 10, 10, 25, 2, (14 << 10) | 5, 512 << 10);
        send_px(OP_PROCESS, 13, 14, 2000, 1'b0);
        send_px(OP_PROCESS, 13, 13, 2000, 1'b0);
        send_px(OP_PROCESS, 10, 10, 2010, 1'b0);
        send_px(OP_PROCESS, 10, 10, 1991, 1'b0);

        // mirrored columns against region bounds
        drain();
        set_registers(-10, 10, 10, 10, 25, 1, (507 << 10) | 498, (14 << 10) | 7);
        send_px(OP_PROCESS, 13, 13, 2000, 1'b0);
        send_px(OP_PROCESS, 5, 20, 3000, 1'b0);
        send_px(OP_PROCESS, 10, 10, 2000, 1'b0);
        send_px(OP_PROCESS, 4, 7, 100, 1'b0);
        send_px(OP_PROCESS, 13, 14, 2000, 1'b0);

        for (ph = 0; ph < 8; ph++) begin
            drain();
            if (ph == 0) begin
                set_registers(-65536, 65535, 511, 511, 1048575, 3, 1023 << 10, 1023 << 10);
            end else if (ph == 1) begin
                // reversed thresholds and empty regions: nothing can mark
                set_registers(65535, -65536, 0, 0, 0, 0, 1023, 20'hFFFFF);
            end else begin
                mn = int'($urandom_range(0, 400)) - 300;
                set_registers(mn, mn + int'($urandom_range(1, 600)),
                              $urandom_range(0, 511), $urandom_range(0, 511),
                              $urandom_range(0, 1048575), $urandom_range(0, 3),
                              ($urandom_range(300, 1023) << 10) | $urandom_range(0, 255),
                              ($urandom_range(300, 1023) << 10) | $urandom_range(0, 255));
            end
            quiet     = (ph == 7);
            gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(5, 40));
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(5, 40));
            for (n = 0; n < 125; n++) random_item();
        end

        drain();
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
